// ===== hw/rtl/lmc_pkg.sv =====
// lmc_pkg: shared types and constants of the log-linear mixture classifier.
// Used by the controller, datapath and top level; no dependencies.
`default_nettype none
package lmc_pkg;

  typedef struct packed {
    logic        func;
    logic [7:0]  weight_addr;
    logic signed [15:0] weight_value;
    logic signed [15:0] sample_value;
    logic        last;
  } lmc_in_t;

  typedef struct packed {
    logic [3:0]  class_index;
    logic [15:0] posterior;
    logic        last_class;
  } lmc_out_t;

  localparam logic FUNC_WEIGHT = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FEAT,   // build product features, one per cycle
    ST_MAC,    // one multiply-accumulate per cycle
    ST_ACT,    // shift, saturate, store activation and track max
    ST_EXP,    // one exp term per cycle
    ST_DIV,    // sum and bit-serial divide for one class
    ST_OUT     // hold result until taken
  } lmc_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic feat_start;
    logic feat_step;
    logic mac_clear;
    logic mac_step;
    logic act_store;
    logic exp_step;
    logic div_start;
    logic div_step;
    logic out_load;
    logic clear_sample;
  } lmc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic feat_done;
    logic mac_done;
    logic act_last;
    logic exp_done;
    logic div_done;
  } lmc_sts_t;

  // 2^(-j/32) in Q1.16 (entry 0 is 1.0)
  function automatic logic [16:0] pow2_tab(input logic [4:0] j);
    logic [16:0] r;
    unique case (j)
      5'd0:  r = 17'd65536; 5'd1:  r = 17'd64132; 5'd2:  r = 17'd62757;
      5'd3:  r = 17'd61413; 5'd4:  r = 17'd60097; 5'd5:  r = 17'd58809;
      5'd6:  r = 17'd57549; 5'd7:  r = 17'd56316; 5'd8:  r = 17'd55109;
      5'd9:  r = 17'd53928; 5'd10: r = 17'd52773; 5'd11: r = 17'd51642;
      5'd12: r = 17'd50535; 5'd13: r = 17'd49452; 5'd14: r = 17'd48393;
      5'd15: r = 17'd47356; 5'd16: r = 17'd46341; 5'd17: r = 17'd45348;
      5'd18: r = 17'd44376; 5'd19: r = 17'd43425; 5'd20: r = 17'd42495;
      5'd21: r = 17'd41584; 5'd22: r = 17'd40693; 5'd23: r = 17'd39821;
      5'd24: r = 17'd38968; 5'd25: r = 17'd38133; 5'd26: r = 17'd37316;
      5'd27: r = 17'd36516; 5'd28: r = 17'd35734; 5'd29: r = 17'd34968;
      5'd30: r = 17'd34219; default: r = 17'd33486;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/loglinear_mixture_classifier_top.sv =====
// Top level of the log-linearized Gaussian mixture classifier.
// Depends on lmc_pkg, lmc_ctrl and lmc_datapath.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o/in_data_i): func=0 writes one
//    weight into the weight memory, func=1 delivers one sample element.
//    Both are accepted only while the block is idle.
//  - A sample element with last set starts the forward pass. in_ready_o
//    stays low until the final class result has been transferred.
//  - Output channel (out_valid_o/out_ready_i/out_data_o): one result per
//    class, in class order; last_class marks the final one.
//  - Sequence: NPROD product features, then per activation a MAC pass
//    over the FEAT features, then NACT exp terms; then per class a sum
//    over its COMPONENTS terms, a bit-serial division (one quotient bit
//    per cycle) and the output transfer. The shared MAC and the
//    bit-serial divider account for most of the time from the last
//    element to the final result transfer.
//  - A stalled receiver holds the current result in the output register;
//    no further work starts until it is taken.
//  - Reset clears the sample buffer and control state; the weight memory
//    is undefined until written.
`default_nettype none
module loglinear_mixture_classifier_top
  import lmc_pkg::*;
#(
  parameter int unsigned IN_DIM     = 4,
  parameter int unsigned CLASSES    = 4,
  parameter int unsigned COMPONENTS = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire lmc_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output lmc_out_t     out_data_o
);

  lmc_cmd_t cmd;
  lmc_sts_t sts;
  logic     busy;
  logic     in_xfer;

  assign in_ready_o = !busy;
  assign in_xfer    = in_valid_i && in_ready_o;

  lmc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i     (in_xfer && in_data_i.func == FUNC_SAMPLE && in_data_i.last),
    .out_ready_i,
    .last_cls_i  (out_data_o.last_class),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .out_valid_o
  );

  lmc_datapath #(
    .IN_DIM     (IN_DIM),
    .CLASSES    (CLASSES),
    .COMPONENTS (COMPONENTS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .in_xfer_i  (in_xfer),
    .in_data_i,
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o
  );

endmodule
`default_nettype wire

// ===== hw/rtl/lmc_ctrl.sv =====
// lmc_ctrl: sequencing state machine of the classifier.
// Depends on lmc_pkg; drives lmc_datapath through lmc_cmd_t / lmc_sts_t.
`default_nettype none
module lmc_ctrl
  import lmc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,     // sample transfer with last set
  input  wire logic     out_ready_i,
  input  wire logic     last_cls_i,  // current result is the last class
  input  wire lmc_sts_t sts_i,
  output lmc_cmd_t      cmd_o,
  output logic          busy_o,
  output logic          out_valid_o
);

  lmc_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_FEAT;
      ST_FEAT: if (sts_i.feat_done) state_d = ST_MAC;
      ST_MAC:  if (sts_i.mac_done) state_d = ST_ACT;
      ST_ACT:  state_d = sts_i.act_last ? ST_EXP : ST_MAC;
      ST_EXP:  if (sts_i.exp_done) state_d = ST_DIV;
      ST_DIV:  if (sts_i.div_done) state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = last_cls_i ? ST_IDLE : ST_DIV;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    busy_o      = (state_q != ST_IDLE);
    out_valid_o = (state_q == ST_OUT);
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.feat_start = start_i;
      end
      ST_FEAT: begin
        cmd_o.feat_step = 1'b1;
        cmd_o.mac_clear = sts_i.feat_done;
      end
      ST_MAC:  cmd_o.mac_step = 1'b1;
      ST_ACT: begin
        cmd_o.act_store = 1'b1;
        cmd_o.mac_clear = 1'b1;
      end
      ST_EXP: begin
        // linear features are no longer needed once all sums are stored
        cmd_o.exp_step     = 1'b1;
        cmd_o.div_start    = sts_i.exp_done;
        cmd_o.clear_sample = sts_i.exp_done;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.out_load = sts_i.div_done;
      end
      ST_OUT:  cmd_o.div_start = out_ready_i && !last_cls_i;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lmc_datapath.sv =====
// lmc_datapath: weight memory, feature store, shared MAC, exp unit and
// bit-serial divider. Depends on lmc_pkg; sequenced by lmc_ctrl.
`default_nettype none
module lmc_datapath
  import lmc_pkg::*;
#(
  parameter int unsigned IN_DIM     = 4,
  parameter int unsigned CLASSES    = 4,
  parameter int unsigned COMPONENTS = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_xfer_i,
  input  wire lmc_in_t  in_data_i,
  input  wire lmc_cmd_t cmd_i,
  output lmc_sts_t      sts_o,
  output lmc_out_t      out_data_o
);

  localparam int unsigned FEAT   = 1 + (IN_DIM * (IN_DIM + 3)) / 2;
  localparam int unsigned NPROD  = FEAT - 1 - IN_DIM;
  localparam int unsigned NACT   = CLASSES * COMPONENTS;
  localparam int unsigned NW     = FEAT * NACT;
  localparam int unsigned FW     = $clog2(FEAT);
  localparam int unsigned AW     = (NACT > 1) ? $clog2(NACT) : 1;
  localparam int unsigned KW     = $clog2(CLASSES);
  localparam int unsigned MW     = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
  localparam int unsigned XW     = $clog2(IN_DIM + 1);
  localparam int unsigned XIW    = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
  localparam int unsigned PW     = (NPROD > 1) ? $clog2(NPROD) : 1;
  localparam int unsigned WAW    = 8;
  localparam int unsigned SW     = 33 + AW;   // sum of exp terms
  localparam logic [WAW:0] NW_L  = (WAW+1)'(NW);

  // ---------------- sample capture ----------------
  logic signed [15:0] smp_q [IN_DIM];
  logic [XW-1:0]      cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < IN_DIM; i++) smp_q[i] <= '0;
    end else if (cmd_i.clear_sample) begin
      cnt_q <= '0;
      for (int i = 0; i < IN_DIM; i++) smp_q[i] <= '0;
    end else if (in_xfer_i && in_data_i.func == FUNC_SAMPLE
                 && cnt_q < XW'(IN_DIM)) begin
      smp_q[cnt_q[XIW-1:0]] <= in_data_i.sample_value;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // ---------------- weight memory ----------------
  logic signed [15:0] wmem [NW];
  logic signed [15:0] wrd_q;
  logic [WAW-1:0]     wrd_addr;

  always_ff @(posedge clk_i) begin
    if (in_xfer_i && in_data_i.func == FUNC_WEIGHT
        && {1'b0, in_data_i.weight_addr} < NW_L) begin
      wmem[in_data_i.weight_addr] <= in_data_i.weight_value;
    end
    wrd_q <= wmem[wrd_addr];
  end

  // ---------------- product features, one per cycle ----------------
  // Products x[a]*x[b] (b>=a) are Q.24; linear features are widened on use.
  logic signed [31:0] prod_q [NPROD];
  logic [XIW-1:0] pa_q, pb_q;
  logic [PW-1:0]  pi_q;
  logic           feat_done;

  assign feat_done = (pi_q == PW'(NPROD - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q <= '0;
      pb_q <= '0;
      pi_q <= '0;
    end else if (cmd_i.feat_start) begin
      pa_q <= '0;
      pb_q <= '0;
      pi_q <= '0;
    end else if (cmd_i.feat_step && !feat_done) begin
      pi_q <= pi_q + 1'b1;
      if (pb_q == XIW'(IN_DIM - 1)) begin
        pa_q <= pa_q + 1'b1;
        pb_q <= pa_q + 1'b1;
      end else begin
        pb_q <= pb_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.feat_step) prod_q[pi_q] <= smp_q[pa_q] * smp_q[pb_q];
  end

  // ---------------- MAC over features ----------------
  // Feature index h runs 0..FEAT; the weight is read in the cycle before its use.
  logic [FW:0]  h_q;        // issue index
  logic         use_q;      // wrd_q valid for feature hu_q
  logic [FW-1:0] hu_q;
  logic [AW-1:0] act_q;     // current activation k*COMPONENTS+m
  logic [KW-1:0] k_q;
  logic [MW-1:0] m_q;
  logic signed [31:0] fsel;
  logic signed [63:0] acc_q;
  logic signed [47:0] term;
  logic          zero_w;

  assign zero_w = (act_q == AW'(NACT - 1));
  assign wrd_addr = WAW'((32'(h_q) * CLASSES + 32'(k_q)) * COMPONENTS + 32'(m_q));

  always_comb begin
    if (hu_q == '0) fsel = 32'sd16777216;
    else if (32'(hu_q) <= IN_DIM) fsel = 32'(smp_q[XIW'(hu_q - 1'b1)]) <<< 12;
    else fsel = prod_q[PW'(32'(hu_q) - 1 - IN_DIM)];
  end
  assign term = fsel * wrd_q;

  assign sts_o.feat_done = feat_done;
  assign sts_o.mac_done  = (h_q == (FW+1)'(FEAT)) && !use_q;
  assign sts_o.act_last  = (act_q == AW'(NACT - 1));

  // activation memory and max tracking
  logic signed [31:0] actv_q [NACT];
  logic signed [31:0] max_q;
  logic signed [43:0] shf;
  logic signed [31:0] sat;

  assign shf = acc_q[63:20];
  always_comb begin
    if (shf > 44'sh0007FFFFFFF)      sat = 32'h7FFFFFFF;
    else if (shf < -44'sh00080000000) sat = 32'h80000000;
    else                              sat = shf[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= '0;
      use_q <= 1'b0;
      hu_q  <= '0;
      act_q <= '0;
      k_q   <= '0;
      m_q   <= '0;
    end else begin
      if (cmd_i.feat_start) begin
        act_q <= '0;
        k_q   <= '0;
        m_q   <= '0;
      end
      if (cmd_i.mac_clear) begin
        h_q   <= '0;
        use_q <= 1'b0;
      end else if (cmd_i.mac_step) begin
        use_q <= (h_q != (FW+1)'(FEAT));
        hu_q  <= h_q[FW-1:0];
        if (h_q != (FW+1)'(FEAT)) h_q <= h_q + 1'b1;
      end
      if (cmd_i.act_store) begin
        act_q <= act_q + 1'b1;
        if (m_q == MW'(COMPONENTS - 1)) begin
          m_q <= '0;
          k_q <= k_q + 1'b1;
        end else begin
          m_q <= m_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_clear) acc_q <= '0;
    else if (cmd_i.mac_step && use_q && !zero_w) acc_q <= acc_q + 64'(term);
    if (cmd_i.act_store) begin
      actv_q[act_q] <= sat;
      if (act_q == '0 || sat > max_q) max_q <= sat;
    end
  end

  // ---------------- exp terms ----------------
  logic [AW-1:0]  ei_q;
  logic           edone_q;
  logic [32:0]    tdiff;
  logic [49:0]    uprod;
  logic [33:0]    u;
  logic [17:0]    n;
  logic [48:0]    ebase;
  logic [32:0]    eval;
  logic [32:0]    ex_q [NACT];
  logic [SW-1:0]  tot_q;

  assign tdiff = 33'($signed({max_q[31], max_q}) - $signed({actv_q[ei_q][31], actv_q[ei_q]}));
  assign uprod = tdiff * LOG2E_Q16;
  assign u     = uprod[49:16];
  assign n     = u[33:16];
  assign ebase = {pow2_tab(u[15:11]), 32'd0} >> 16;
  assign eval  = (n > 18'd47) ? '0 : 33'(ebase >> n[5:0]);
  assign sts_o.exp_done = edone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ei_q    <= '0;
      edone_q <= 1'b0;
    end else if (cmd_i.feat_start) begin
      ei_q    <= '0;
      edone_q <= 1'b0;
    end else if (cmd_i.exp_step && !edone_q) begin
      ei_q <= ei_q + 1'b1;
      if (ei_q == AW'(NACT - 1)) edone_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.feat_start) tot_q <= '0;
    else if (cmd_i.exp_step && !edone_q) begin
      ex_q[ei_q] <= eval;
      tot_q <= tot_q + SW'(eval);
    end
  end

  // ---------------- per-class sum and restoring divider ----------------
  // Numerator C_k*65536 + S/2; quotient needs only 17 bits (C_k <= S).
  localparam int unsigned NUMW = SW + 17;
  localparam int unsigned QB   = 17;
  logic [KW-1:0]   oc_q;
  logic [MW:0]     cs_cnt_q;
  logic [SW-1:0]   cs_q;
  logic [NUMW-1:0] num_q;
  logic [SW:0]     rem_q;
  logic [QB-1:0]   quo_q;
  logic [5:0]      bit_q;
  logic            summing_q;
  logic            ddone_q;
  logic [SW+1:0]   rtry;
  logic [AW-1:0]   cs_idx;
  logic            first_q;

  assign cs_idx = AW'(32'(oc_q) * COMPONENTS + 32'(cs_cnt_q));
  assign rtry   = {rem_q, num_q[NUMW-1]} - {2'b00, tot_q};
  assign sts_o.div_done = ddone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_q <= '0;
      summing_q <= 1'b0;
      ddone_q <= 1'b0;
      first_q <= 1'b1;
    end else begin
      if (cmd_i.feat_start) begin
        first_q <= 1'b1;
      end
      if (cmd_i.div_start) begin
        summing_q <= 1'b1;
        ddone_q   <= 1'b0;
        if (!first_q) oc_q <= oc_q + 1'b1;
        else oc_q <= '0;
        first_q <= 1'b0;
      end else if (cmd_i.div_step && !ddone_q) begin
        if (summing_q) begin
          if (cs_cnt_q == (MW+1)'(COMPONENTS)) summing_q <= 1'b0;
        end else if (bit_q == 6'(NUMW - 1)) begin
          ddone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      cs_cnt_q <= '0;
      cs_q     <= '0;
      bit_q    <= '0;
    end else if (cmd_i.div_step && !ddone_q) begin
      if (summing_q) begin
        if (cs_cnt_q != (MW+1)'(COMPONENTS)) begin
          cs_q     <= cs_q + SW'(ex_q[cs_idx]);
          cs_cnt_q <= cs_cnt_q + 1'b1;
        end else begin
          num_q <= NUMW'({cs_q, 16'd0}) + NUMW'(tot_q >> 1);
          rem_q <= '0;
          quo_q <= '0;
        end
      end else begin
        bit_q <= bit_q + 1'b1;
        num_q <= num_q << 1;
        if (!rtry[SW+1]) begin
          rem_q <= rtry[SW:0];
          quo_q <= {quo_q[QB-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[SW-1:0], num_q[NUMW-1]};
          quo_q <= {quo_q[QB-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_o.class_index <= 4'(oc_q);
      out_data_o.posterior   <= quo_q[16] ? 16'hFFFF : quo_q[15:0];
      out_data_o.last_class  <= (oc_q == KW'(CLASSES - 1));
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lmc_checker.sv =====
// lmc_checker: port-level checks on the classifier, bound to the top level.
// Depends on lmc_pkg.
`default_nettype none
module lmc_checker
  import lmc_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire lmc_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire lmc_out_t out_data_o
);

  // No input is taken while a result waits
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready during output");

  // Result held under stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  // After last class is taken, block returns to ready
  a_last_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_class |=> in_ready_o)
    else $error("not ready after last class");

  // A sample with last closes the input side
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func == FUNC_SAMPLE && in_data_i.last
    |=> !in_ready_o) else $error("ready after last element");

endmodule

bind loglinear_mixture_classifier_top lmc_checker u_lmc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
  .out_valid_o, .out_ready_i, .out_data_o
);
`default_nettype wire
